/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled at the rising edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled at the rising edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/fca_pkg.sv */
package fca_pkg;

  localparam int CNT_W   = 13;  // entry counts, hint, scan position
  localparam int IDX_W   = 12;
  localparam int WORD_W  = 32;
  localparam int ENTRY_W = 28;

  localparam logic [2:0] REQ_LOAD  = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_ALLOC = 3'd2;
  localparam logic [2:0] REQ_LINK  = 3'd3;
  localparam logic [2:0] REQ_COUNT = 3'd4;

  localparam logic REG_IN_USE   = 1'b0;
  localparam logic REG_EOC_MARK = 1'b1;

  localparam logic [WORD_W-1:0]  ALLOC_MARK     = 32'h0FFF_FFFF;
  localparam logic [CNT_W-1:0]   RESET_IN_USE   = 13'd4096;
  localparam logic [ENTRY_W-1:0] RESET_EOC_MARK = 28'hFFF_FFF8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCAN,
    ST_DONE
  } fca_state_t;

  typedef struct packed {
    logic capture;     // latch the incoming word
    logic write_req;   // load or link write
    logic read_req;    // read-next lookup
    logic take_read;   // latch read-next result
    logic scan_init;   // set up allocate or count scan
    logic scan_step;   // advance scan by one entry
    logic scan_close;  // scan ran out without a hit
    logic out_load;    // move result into output register
  } fca_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       hit;
    logic       scan_end;
    logic       out_free;
  } fca_status_t;

endpackage

/* hw/rtl/fca_ctrl.sv */
`include "assert_macros.svh"

module fca_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fca_pkg::fca_status_t status,
  output fca_pkg::fca_cmd_t    cmd
);
  import fca_pkg::*;

  fca_state_t state;
  fca_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.kind == REQ_READ) begin
          state_next = ST_RDWAIT;
        end else if (status.kind == REQ_ALLOC || status.kind == REQ_COUNT) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_SCAN: begin
        if (status.hit || status.scan_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.capture = in_valid;
      ST_EXEC: begin
        cmd.write_req = (status.kind == REQ_LOAD) || (status.kind == REQ_LINK);
        cmd.read_req  = (status.kind == REQ_READ);
        cmd.scan_init = (status.kind == REQ_ALLOC) || (status.kind == REQ_COUNT);
      end
      ST_RDWAIT: cmd.take_read = 1'b1;
      ST_SCAN: begin
        cmd.scan_step  = 1'b1;
        cmd.scan_close = status.scan_end;
      end
      ST_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

  `ASSERT_NEXT(a_accept_exec, clk, rst, in_valid && in_ready, state == ST_EXEC)

endmodule

/* hw/rtl/fca_dpath.sv */
`include "assert_macros.svh"

module fca_dpath #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [2:0]                   req_type,
  input  logic [fca_pkg::IDX_W-1:0]    entry_index,
  input  logic [fca_pkg::WORD_W-1:0]   entry_value,
  input  logic [fca_pkg::CNT_W-1:0]    entries_in_use,
  input  logic [fca_pkg::ENTRY_W-1:0]  end_of_chain_mark,
  input  fca_pkg::fca_cmd_t            cmd,
  output fca_pkg::fca_status_t         status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fca_pkg::ENTRY_W-1:0]  result_value,
  output logic                         end_of_chain,
  output logic                         alloc_failed
);
  import fca_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  // captured request
  logic [2:0]        req_kind;
  logic [IDX_W-1:0]  req_idx;
  logic [WORD_W-1:0] req_val;
  logic              req_in_range;

  // table
  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  // scan
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] hint;
  logic [CNT_W-1:0] scan_addr;
  logic [CNT_W-1:0] scan_addr_inc;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] pend_idx;
  logic             pend_valid;
  logic [CNT_W-1:0] free_count;
  logic             zero_seen;
  logic             hit;
  logic             hit_commit;
  logic             issue;

  // result
  logic [ENTRY_W-1:0] res_value;
  logic               res_eoc;
  logic               res_fail;

  always_comb begin
    if (32'(entries_in_use) > 32'(TABLE_ENTRIES)) begin
      lim = CNT_W'(TABLE_ENTRIES);
    end else begin
      lim = entries_in_use;
    end
  end

  assign zero_seen     = pend_valid && (rd_data == '0);
  assign hit           = zero_seen && (req_kind == REQ_ALLOC);
  assign hit_commit    = cmd.scan_step && hit;
  assign issue         = cmd.scan_step && !hit && (remaining != '0);
  assign scan_addr_inc = scan_addr + 1'b1;

  assign rd_en   = cmd.read_req || issue;
  assign rd_addr = cmd.read_req ? AW'(req_idx) : AW'(scan_addr);
  assign wr_en   = (cmd.write_req && req_in_range) || hit_commit;
  assign wr_addr = hit_commit ? AW'(pend_idx) : AW'(req_idx);
  assign wr_data = hit_commit ? ALLOC_MARK : req_val;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind     <= req_type;
      req_idx      <= entry_index;
      req_val      <= entry_value;
      req_in_range <= 32'(entry_index) < 32'(TABLE_ENTRIES);
    end
  end

  // walk one entry per cycle, wrapping at the in-use limit
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      hint       <= '0;
    end else if (cmd.scan_init) begin
      scan_addr  <= (hint < lim) ? hint : '0;
      remaining  <= lim;
      pend_valid <= 1'b0;
      free_count <= '0;
    end else if (cmd.scan_step) begin
      if (zero_seen && req_kind == REQ_COUNT) free_count <= free_count + 1'b1;
      if (hit_commit) hint <= pend_idx + 1'b1;
      if (issue) begin
        pend_valid <= 1'b1;
        pend_idx   <= scan_addr;
        scan_addr  <= (scan_addr_inc == lim) ? '0 : scan_addr_inc;
        remaining  <= remaining - 1'b1;
      end else begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_value <= '0;
      res_eoc   <= 1'b0;
      res_fail  <= 1'b0;
    end else if (cmd.take_read) begin
      if (req_in_range) begin
        res_value <= rd_data[ENTRY_W-1:0];
        res_eoc   <= rd_data[ENTRY_W-1:0] >= end_of_chain_mark;
      end
    end else if (hit_commit) begin
      res_value <= ENTRY_W'(pend_idx);
    end else if (cmd.scan_close) begin
      if (req_kind == REQ_ALLOC) begin
        res_fail <= 1'b1;
      end else begin
        res_value <= ENTRY_W'(free_count);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= res_value;
      end_of_chain <= res_eoc;
      alloc_failed <= res_fail;
    end
  end

  assign status.kind     = req_kind;
  assign status.hit      = hit;
  assign status.scan_end = (remaining == '0) && !pend_valid;
  assign status.out_free = !out_valid || out_ready;

  `ASSERT_IMPLY(a_scan_addr_in_range, clk, rst, issue, scan_addr < lim)
  `ASSERT_IMPLY(a_count_bound, clk, rst, cmd.scan_step, (CNT_W+1)'(free_count) + (CNT_W+1)'(remaining) <= (CNT_W+1)'(lim))
  `ASSERT_NEXT(a_hint_follows, clk, rst, hit_commit, hint == $past(pend_idx) + 1'b1)

endmodule

/* hw/rtl/fat_cluster_allocator_core.sv */
// Channel  Handshake            Payload / use
// -------  -------------------  ----------------------------------------------
// in       in_valid/in_ready    req_type, entry_index, entry_value
// out      out_valid/out_ready  result_value, end_of_chain, alloc_failed
// cfg      psel/penable/pready  paddr 0: entries_in_use, 4: end_of_chain_mark
//
// Steps per word: capture, execute and delivery for load, link and unknown
// kinds; read-next adds a read wait, and count-free and allocate add a scan of
// the entries in use (capped at the table size), which a successful allocate
// ends at its hit. The scan reads one table entry per cycle.
// Reset (rst, synchronous) clears the hint, controller and output valid.
// A stalled output holds the controller in its last step until it frees.
module fat_cluster_allocator_core #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          req_type,
  input  logic [fca_pkg::IDX_W-1:0]           entry_index,
  input  logic [fca_pkg::WORD_W-1:0]          entry_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fca_pkg::ENTRY_W-1:0]         result_value,
  output logic                                end_of_chain,
  output logic                                alloc_failed,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import fca_pkg::*;

  logic [CNT_W-1:0]   entries_in_use;
  logic [ENTRY_W-1:0] end_of_chain_mark;
  logic               cfg_write;
  logic               reg_sel;

  fca_cmd_t    cmd;
  fca_status_t status;

  // Registers are word aligned; bit 2 picks one, low bits are ignored.
  assign reg_sel   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use    <= RESET_IN_USE;
      end_of_chain_mark <= RESET_EOC_MARK;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_IN_USE:   entries_in_use    <= pwdata[CNT_W-1:0];
        REG_EOC_MARK: end_of_chain_mark <= pwdata[ENTRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value, zero-extended to the bus.
  always_comb begin
    unique case (reg_sel)
      REG_IN_USE:   prdata = 32'(entries_in_use);
      REG_EOC_MARK: prdata = 32'(end_of_chain_mark);
      default:      prdata = '0;
    endcase
  end

  // Sequencer: steps each word through capture, execute, read wait or scan, and delivery.
  fca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table memory, next-fit hint, scan counters and the output register.
  fca_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .req_type          (req_type),
    .entry_index       (entry_index),
    .entry_value       (entry_value),
    .entries_in_use    (entries_in_use),
    .end_of_chain_mark (end_of_chain_mark),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .result_value      (result_value),
    .end_of_chain      (end_of_chain),
    .alloc_failed      (alloc_failed)
  );

endmodule

/* sim/tb_fat_cluster_allocator_core.sv */
`timescale 1ns / 1ps

module tb_fat_cluster_allocator_core;
  import fca_pkg::*;

  localparam int     TBL_DEPTH    = 4096;
  localparam int     LONG_HOLD    = 400;    // receiver hold-off, in cycles
  localparam int     HOLD_STRIDE  = 1200;   // results between hold-offs
  localparam longint CYCLE_LIMIT  = 3_000_000;
  localparam int     SMALL_PHASES = 7;
  localparam int     SMALL_WORDS  = 140;
  localparam int     FULL_WORDS   = 110;
  localparam int     FILL_CAP     = 128;    // entries loaded up front per phase
  localparam int     TAIL_CYCLES  = 64;
  localparam int     SHOW_MAX     = 10;

  // request kinds the block must answer with an all-zero result
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam logic [CNT_W-1:0]   IN_USE_OVER = 13'h1FFF;
  localparam logic [ENTRY_W-1:0] EOC_TOP     = 28'hFFF_FFFF;

  typedef struct packed {
    logic [ENTRY_W-1:0] value;
    logic               eoc;
    logic               fail;
  } fat_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // One line of the directed table: either a request word with its typed-in
  // result, or a register write done while the block is idle.
  typedef struct packed {
    row_kind_t          kind;
    logic               reg_sel;
    logic [2:0]         req;
    logic [IDX_W-1:0]   idx;
    logic [WORD_W-1:0]  data;
    fat_result_t        want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [2:0]          req_type;
  logic [IDX_W-1:0]    entry_index;
  logic [WORD_W-1:0]   entry_value;
  logic                out_valid;
  logic                out_ready;
  logic [ENTRY_W-1:0]  result_value;
  logic                end_of_chain;
  logic                alloc_failed;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  fat_cluster_allocator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .end_of_chain (end_of_chain),
    .alloc_failed (alloc_failed),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow copy of the allocator: table, load marks, hint and registers.
  logic [WORD_W-1:0]  shadow_fat [TBL_DEPTH];
  bit                 loaded [TBL_DEPTH];
  int                 loaded_list [$];
  logic [CNT_W-1:0]   shadow_hint;
  logic [CNT_W-1:0]   shadow_in_use;
  logic [ENTRY_W-1:0] shadow_eoc_mark;

  // Results owed by the block, oldest first.
  fat_result_t        due_results [$];

  longint             cycles;
  int unsigned        words_sent;
  int unsigned        results_seen;
  int unsigned        mismatches;
  int unsigned        allocs_ok;
  int unsigned        allocs_failed;
  int unsigned        counts_done;
  int unsigned        reg_writes;
  bit                 send_steady;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Give up on a hung run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("  timeout after %0d cycles, %0d results still due", cycles,
               due_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Entries actually scanned: the in-use count is capped at the table size.
  function automatic int active_span();
    return (shadow_in_use > TBL_DEPTH) ? TBL_DEPTH : int'(shadow_in_use);
  endfunction

  function automatic void store_entry(int idx, logic [WORD_W-1:0] w);
    shadow_fat[idx] = w;
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endfunction

  // True when a scan of this kind touches only entries that were written.
  function automatic bit scan_defined(bit is_alloc);
    int span;
    int upper;
    span  = active_span();
    upper = (int'(shadow_hint) < span) ? int'(shadow_hint) : span;
    if (!is_alloc) begin
      for (int i = 0; i < span; i++)
        if (!loaded[i]) return 1'b0;
      return 1'b1;
    end
    for (int i = int'(shadow_hint); i < span; i++) begin
      if (!loaded[i]) return 1'b0;
      if (shadow_fat[i] == '0) return 1'b1;
    end
    for (int i = 0; i < upper; i++) begin
      if (!loaded[i]) return 1'b0;
      if (shadow_fat[i] == '0) return 1'b1;
    end
    return 1'b1;
  endfunction

  // Apply one request word to the shadow state and return its result.
  function automatic fat_result_t serve_request(logic [2:0] req, logic [IDX_W-1:0] idx,
                                                logic [WORD_W-1:0] w);
    fat_result_t r;
    int          span;
    int          upper;
    int          hit;
    r = '0;
    span = active_span();
    case (req)
      REQ_LOAD, REQ_LINK: store_entry(int'(idx), w);
      REQ_READ: begin
        // keep the low 28 bits, as FAT32 does
        r.value = shadow_fat[idx][ENTRY_W-1:0];
        r.eoc   = (r.value >= shadow_eoc_mark);
      end
      REQ_ALLOC: begin
        // next fit: hint up to the end, then wrap to the start up to the hint
        hit = -1;
        upper = (int'(shadow_hint) < span) ? int'(shadow_hint) : span;
        for (int i = int'(shadow_hint); i < span && hit < 0; i++)
          if (shadow_fat[i] == '0) hit = i;
        for (int i = 0; i < upper && hit < 0; i++)
          if (shadow_fat[i] == '0) hit = i;
        if (hit >= 0) begin
          shadow_fat[hit] = ALLOC_MARK;
          shadow_hint = CNT_W'(hit + 1);
          r.value = ENTRY_W'(hit);
          allocs_ok++;
        end else begin
          r.fail = 1'b1;
          allocs_failed++;
        end
      end
      REQ_COUNT: begin
        for (int i = 0; i < span; i++)
          if (shadow_fat[i] == '0) r.value++;
        counts_done++;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_miss(input string what, input longint unsigned want,
                             input longint unsigned got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("  mismatch %0d at cycle %0d: %s expected 0x%0h got 0x%0h",
               mismatches, cycles, what, want, got);
  endtask

  // Compare every accepted result word with the oldest one owed.
  always @(posedge clk) begin
    fat_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_miss("result with none due, value", 0, result_value);
      end else begin
        want = due_results.pop_front();
        if (result_value !== want.value)
          report_miss("result_value", want.value, result_value);
        if (end_of_chain !== want.eoc)
          report_miss("end_of_chain", want.eoc, end_of_chain);
        if (alloc_failed !== want.fail)
          report_miss("alloc_failed", want.fail, alloc_failed);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one; none at all in a steady run.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Table words: free entries, short chain links, end-of-chain marks with
  // noise in the reserved top nibble, and raw random words.
  function automatic logic [WORD_W-1:0] pick_word(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 55) return WORD_W'($urandom_range(2, span + 1));
    if (r < 70) return {4'($urandom_range(0, 15)), RESET_EOC_MARK + 28'($urandom_range(0, 7))};
    return $urandom;
  endfunction

  // Reads stay on loaded entries only.
  function automatic logic [IDX_W-1:0] read_index(int span);
    int i;
    i = $urandom_range(0, span - 1);
    if ($urandom_range(0, 99) < 60 && loaded[i]) return IDX_W'(i);
    return IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  function automatic logic [IDX_W-1:0] write_index(int span);
    if ($urandom_range(0, 99) < 65) return IDX_W'($urandom_range(0, span - 1));
    return IDX_W'($urandom);
  endfunction

  // Offer one word, hold it until accepted, then book its result. Leaves
  // valid high on return so back-to-back words need no second assignment.
  task automatic push_word(input logic [2:0] req, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] w, input bit typed,
                           input fat_result_t typed_res);
    int          gap;
    fat_result_t r;
    gap = pick_gap(send_steady);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    req_type    = req;
    entry_index = idx;
    entry_value = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = serve_request(req, idx, w);
    due_results.push_back(typed ? typed_res : r);
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic settle();
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // Register write (setup, access) followed by a read-back of the same register.
  task automatic write_reg(input logic sel, input logic [31:0] v);
    logic [31:0] mask;
    mask = (sel == REG_IN_USE) ? 32'h0000_1FFF : 32'h0FFF_FFFF;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_IN_USE) shadow_in_use = v[CNT_W-1:0];
    else shadow_eoc_mark = v[ENTRY_W-1:0];
    reg_writes++;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (v & mask))
      report_miss("register read-back", v & mask, prdata & mask);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Load every entry below the given bound that was never written.
  task automatic fill_span(input int span, input int zero_pct);
    for (int i = 0; i < span; i++)
      if (!loaded[i])
        push_word(REQ_LOAD, IDX_W'(i),
                  ($urandom_range(0, 99) < zero_pct) ? 32'd0 : pick_word(span),
                  1'b0, '0);
  endtask

  // Scans that would reach an unwritten entry turn into reads instead.
  task automatic random_word(input int span, input int count_wt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      push_word(REQ_READ, read_index(span), $urandom, 1'b0, '0);
    end else if (r < 55) begin
      if (scan_defined(1'b1))
        push_word(REQ_ALLOC, IDX_W'($urandom), $urandom, 1'b0, '0);
      else
        push_word(REQ_READ, read_index(span), $urandom, 1'b0, '0);
    end else if (r < 75) begin
      push_word(REQ_LINK, write_index(span), pick_word(span), 1'b0, '0);
    end else if (r < 85) begin
      push_word(REQ_LOAD, write_index(span), pick_word(span), 1'b0, '0);
    end else if (r < 85 + count_wt) begin
      if (scan_defined(1'b0))
        push_word(REQ_COUNT, IDX_W'($urandom), $urandom, 1'b0, '0);
      else
        push_word(REQ_READ, read_index(span), $urandom, 1'b0, '0);
    end else if (r >= 97) begin
      push_word(3'($urandom_range(REQ_RSVD5, REQ_RSVD7)), IDX_W'($urandom), $urandom,
                1'b0, '0);
    end else begin
      push_word(REQ_READ, read_index(span), $urandom, 1'b0, '0);
    end
  endtask

  function automatic dir_row_t w_row(logic [2:0] req, logic [IDX_W-1:0] idx,
                                     logic [WORD_W-1:0] data, logic [ENTRY_W-1:0] value,
                                     logic eoc, logic fail);
    dir_row_t row;
    row            = '0;
    row.kind       = ROW_WORD;
    row.req        = req;
    row.idx        = idx;
    row.data       = data;
    row.want.value = value;
    row.want.eoc   = eoc;
    row.want.fail  = fail;
    return row;
  endfunction

  function automatic dir_row_t r_row(logic sel, logic [WORD_W-1:0] data);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_sel = sel;
    row.data    = data;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure plus a periodic long hold-off that
  // backs the block up until it stalls its request channel.
  // ---------------------------------------------------------------------------
  initial begin
    int          gap_left;
    int          hold_left;
    int unsigned hold_at;
    bit          steady;
    out_ready = 1'b0;
    gap_left  = 0;
    hold_left = 0;
    hold_at   = 300;
    steady    = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (results_seen >= hold_at) begin
        // hold off long enough for the request side to back up
        out_ready = 1'b0;
        hold_left = LONG_HOLD - 1;
        hold_at   = hold_at + HOLD_STRIDE;
      end else if (gap_left > 0) begin
        out_ready = 1'b0;
        gap_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 255) == 0) steady = !steady;
        if ($urandom_range(0, 3) == 0) gap_left = pick_gap(steady);
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Request side and run control
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t           rows [$];
    int                 span;
    int                 span_eff;
    int                 n_words;
    logic [ENTRY_W-1:0] mark;

    // every input known from time zero
    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = REQ_LOAD;
    entry_index = '0;
    entry_value = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    send_steady = 1'b0;
    words_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;
    allocs_ok     = 0;
    allocs_failed = 0;
    counts_done   = 0;
    reg_writes    = 0;

    shadow_hint     = '0;
    shadow_in_use   = RESET_IN_USE;
    shadow_eoc_mark = RESET_EOC_MARK;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed table. Reset registers first: full table, mark 0x0FFFFFF8.
    // Reserved top nibble must vanish on read-next.
    rows.push_back(w_row(REQ_LOAD,  12'd0,    32'hFFFF_FFFF, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_READ,  12'd0,    32'h0000_0000, 28'hFFF_FFFF,  1'b1, 1'b0));
    rows.push_back(w_row(REQ_LOAD,  12'd4095, 32'h0FFF_FFF7, 28'd0,         1'b0, 1'b0));
    // one below the end mark, top index
    rows.push_back(w_row(REQ_READ,  12'd4095, 32'hFFFF_FFFF, 28'hFFF_FFF7,  1'b0, 1'b0));
    rows.push_back(w_row(REQ_LOAD,  12'd1,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_READ,  12'd1,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    // first free entry from a zero hint is index 1
    rows.push_back(w_row(REQ_ALLOC, 12'd0,    32'h0000_0000, 28'd1,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_READ,  12'd1,    32'h0000_0000, 28'hFFF_FFFF,  1'b1, 1'b0));
    rows.push_back(w_row(REQ_LINK,  12'd2,    32'hF000_0005, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_READ,  12'd2,    32'h0000_0000, 28'd5,         1'b0, 1'b0));
    // exactly at the end mark
    rows.push_back(w_row(REQ_LOAD,  12'd3,    32'h0FFF_FFF8, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_READ,  12'd3,    32'h0000_0000, 28'hFFF_FFF8,  1'b1, 1'b0));
    // reserved kinds answer all zero and touch nothing
    rows.push_back(w_row(REQ_RSVD5, 12'd4095, 32'hFFFF_FFFF, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_RSVD6, 12'd0,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_RSVD7, 12'd2,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    // no entries in use: allocate fails, count is zero
    rows.push_back(r_row(REG_IN_USE, 32'd0));
    rows.push_back(w_row(REQ_ALLOC, 12'd0,    32'h0000_0000, 28'd0,         1'b0, 1'b1));
    rows.push_back(w_row(REQ_COUNT, 12'd0,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    // hint (2) past the single entry in use: only the wrap scan runs
    rows.push_back(r_row(REG_IN_USE, 32'd1));
    rows.push_back(w_row(REQ_ALLOC, 12'd0,    32'h0000_0000, 28'd0,         1'b0, 1'b1));
    rows.push_back(w_row(REQ_LOAD,  12'd0,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_ALLOC, 12'd0,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_COUNT, 12'd0,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    // mark at zero: every read ends a chain, even a free entry
    rows.push_back(r_row(REG_EOC_MARK, 32'd0));
    rows.push_back(w_row(REQ_LINK,  12'd5,    32'h0000_0000, 28'd0,         1'b0, 1'b0));
    rows.push_back(w_row(REQ_READ,  12'd5,    32'h0000_0000, 28'd0,         1'b1, 1'b0));
    // mark at the top: only the allocation mark itself ends a chain
    rows.push_back(r_row(REG_EOC_MARK, 32'(EOC_TOP)));
    rows.push_back(w_row(REQ_READ,  12'd0,    32'h0000_0000, 28'hFFF_FFFF,  1'b1, 1'b0));
    rows.push_back(w_row(REQ_READ,  12'd4095, 32'h0000_0000, 28'hFFF_FFF7,  1'b0, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        settle();
        write_reg(rows[i].reg_sel, rows[i].data);
      end else begin
        push_word(rows[i].req, rows[i].idx, rows[i].data, 1'b1, rows[i].want);
      end
    end

    // Random phases. Each one idles the block, picks a setting, loads the
    // low entries in use, then mixes requests. Small spans keep scans cheap;
    // the last two set the full table and an oversized entry count, with
    // scans kept to entries that were written.
    for (int p = 0; p < SMALL_PHASES + 2; p++) begin
      settle();
      if (p == 0) span = 2;
      else if (p == 1) span = 128;
      else if (p < SMALL_PHASES) span = $urandom_range(3, 96);
      else if (p == SMALL_PHASES) span = TBL_DEPTH;
      else span = int'(IN_USE_OVER);
      case ($urandom_range(0, 3))
        0: mark = RESET_EOC_MARK;
        1: mark = ENTRY_W'($urandom);
        2: mark = ENTRY_W'($urandom_range(0, 200));
        default: mark = EOC_TOP - ENTRY_W'($urandom_range(0, 3));
      endcase
      write_reg(REG_IN_USE, 32'(span));
      write_reg(REG_EOC_MARK, 32'(mark));
      span_eff = active_span();
      fill_span((span_eff < FILL_CAP) ? span_eff : FILL_CAP,
                (p < SMALL_PHASES) ? 35 : 6);
      n_words = (p < SMALL_PHASES) ? SMALL_WORDS : FULL_WORDS;
      for (int k = 0; k < n_words; k++) begin
        // alternate gappy and back-to-back stretches
        if (k % 64 == 0) send_steady = ($urandom_range(0, 3) == 0);
        random_word(span_eff, (p < SMALL_PHASES) ? 9 : 2);
      end
    end

    // drain, then watch a little longer for stray results
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += due_results.size();

    $display("  %0d words, %0d results checked, %0d allocations (%0d failed), %0d free counts",
             words_sent, results_seen, allocs_ok + allocs_failed, allocs_failed, counts_done);
    $display("  %0d register writes, entry counts from none to the whole table and past it",
             reg_writes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
